// ===== design/b64d_pkg.sv =====
// Shared types, constants and the character classifier of the Base64 decoder.
package b64d_pkg;

  // Default width of the per-message byte counter.
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  // Width of the capacity register and of the reported length.
  localparam int unsigned CAP_WIDTH = 16;
  localparam int unsigned LEN_WIDTH = 16;
  // Depth of the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  // Capacity after reset.
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'hFFFF;

  // Classifier codes outside the 6-bit symbol range.
  localparam logic [7:0] SYM_SKIP = 8'd255;
  localparam logic [7:0] SYM_PAD  = 8'd254;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DATA       = 2'd0,
    ST_DONE       = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_e;

  // One input beat.
  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_message;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [7:0]           out_byte;
    logic [1:0]           status;
    logic [LEN_WIDTH-1:0] total_len;
    logic                 run_end;
  } out_beat_t;

  // Work handed from front to back for one input beat (counts travel apart).
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  nbytes;
    logic        has_stat;
    status_e     stat;
  } job_t;

  // Maps a character to its 6-bit symbol, SYM_PAD for '=' or SYM_SKIP.
  function automatic logic [7:0] symbol_of(input logic [7:0] ch);
    logic [7:0] sym;
    sym = SYM_SKIP;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      sym = ch - 8'h41;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      sym = ch - 8'h61 + 8'd26;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      sym = ch - 8'h30 + 8'd52;
    end else if (ch == 8'h2B) begin
      sym = 8'd62;
    end else if (ch == 8'h2F) begin
      sym = 8'd63;
    end else if (ch == 8'h3D) begin
      sym = SYM_PAD;
    end
    return sym;
  endfunction

endpackage

// ===== design/base64_decoder_core.sv =====
// Base64 stream decoder: one character beat in, zero to four result beats out.
// A result beat passes through the job queue and then the output register after its input beat.
// Throughput: one input beat per cycle unless in_stall_o is raised because the job queue is full;
// the back end sends one result beat per cycle unless the output stalls, with a four-entry job queue between.
// Reset: capacity returns to 65535 and the message state to its start; no clearing pass.
module base64_decoder_core #(
  parameter int unsigned CountWidth = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [b64d_pkg::CAP_WIDTH-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  b64d_pkg::in_beat_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output b64d_pkg::out_beat_t            out_data_o
);
  import b64d_pkg::*;

  localparam int unsigned QWidth = $bits(job_t) + 2 * CountWidth;

  logic                  push, pop, q_empty, q_full;
  job_t                  job_push, job_head;
  logic [CountWidth-1:0] base_push, base_head;
  logic [CountWidth-1:0] slen_push, slen_head;

  // The capacity register takes a write every cycle.
  assign cfg_ready_o = 1'b1;

  // Character intake and message state.
  b64d_front #(.CountWidth(CountWidth)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .queue_full_i (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .job_o        (job_push),
    .base_o       (base_push),
    .stat_len_o   (slen_push)
  );

  // Job queue.
  b64d_queue #(.DataWidth(QWidth), .Depth(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({job_push, base_push, slen_push}),
    .pop_i   (pop),
    .data_o  ({job_head, base_head, slen_head}),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Result beat generation.
  b64d_back #(.CountWidth(CountWidth)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .job_i        (job_head),
    .base_i       (base_head),
    .stat_len_i   (slen_head),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== design/b64d_front.sv =====
// Front end: accepts characters, tracks group and message state, issues jobs.
module b64d_front #(
  parameter int unsigned CountWidth = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [b64d_pkg::CAP_WIDTH-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  b64d_pkg::in_beat_t             in_data_i,
  input  logic                           queue_full_i,
  output logic                           in_stall_o,
  output logic                           push_o,
  output b64d_pkg::job_t                 job_o,
  output logic [CountWidth-1:0]          base_o,
  output logic [CountWidth-1:0]          stat_len_o
);
  import b64d_pkg::*;

  localparam int unsigned CmpWidth =
    ((CountWidth > CAP_WIDTH) ? CountWidth : CAP_WIDTH) + 1;

  logic [CAP_WIDTH-1:0]  cap_q;
  logic [17:0]           accum_q, accum_d;
  logic [1:0]            cnt_q, cnt_d;
  logic [1:0]            budget_q, budget_d;
  logic [CountWidth-1:0] bw_q, bw_d;
  logic                  discard_q, discard_d;

  logic                  accept;
  logic [7:0]            sym;
  logic                  is_sym;
  logic                  is_pad;
  logic [5:0]            val;
  logic [1:0]            budget_new;
  logic                  complete;
  logic [1:0]            n;
  logic [CmpWidth-1:0]   sum;
  logic                  ovf;
  logic                  last;
  logic [CountWidth-1:0] bw_after;
  job_t                  job;
  logic [CountWidth-1:0] stat_len;

  assign accept     = in_valid_i && !queue_full_i;
  assign in_stall_o = queue_full_i;
  assign last       = in_data_i.end_of_message;

  // Classify the character and form the next group state.
  always_comb begin
    sym        = symbol_of(in_data_i.in_char);
    is_sym     = (sym != SYM_SKIP);
    is_pad     = (sym == SYM_PAD);
    val        = is_pad ? 6'd0 : sym[5:0];
    budget_new = (is_pad && budget_q != 2'd0) ? budget_q - 2'd1 : budget_q;
    complete   = is_sym && (cnt_q == 2'd3);
    n          = (budget_new == 2'd0) ? 2'd1 : budget_new;
    sum        = CmpWidth'(bw_q) + CmpWidth'(n);
    ovf        = complete && (sum > CmpWidth'(cap_q));
  end

  // Build the job and the next message state.
  always_comb begin
    job          = '0;
    job.stat     = ST_DONE;
    job.group    = {accum_q, val};
    stat_len     = bw_q;
    bw_after     = bw_q;
    accum_d      = accum_q;
    cnt_d        = cnt_q;
    budget_d     = budget_q;
    bw_d         = bw_q;
    discard_d    = discard_q;
    if (!discard_q) begin
      if (is_sym) begin
        accum_d  = {accum_q[11:0], val};
        cnt_d    = cnt_q + 2'd1;
        budget_d = budget_new;
      end
      if (complete) begin
        if (ovf) begin
          job.has_stat = 1'b1;
          job.stat     = ST_OVERFLOW;
          discard_d    = 1'b1;
        end else begin
          job.nbytes = n;
          bw_after   = bw_q + CountWidth'(n);
        end
        bw_d = bw_after;
      end
      if (last && !ovf) begin
        job.has_stat = 1'b1;
        job.stat     = (cnt_d != 2'd0) ? ST_INCOMPLETE : ST_DONE;
        stat_len     = bw_after;
      end
    end
    if (last) begin
      accum_d   = '0;
      cnt_d     = 2'd0;
      budget_d  = 2'd3;
      bw_d      = '0;
      discard_d = 1'b0;
    end
  end

  assign push_o     = accept && !discard_q && (job.nbytes != 2'd0 || job.has_stat);
  assign job_o      = job;
  assign base_o     = bw_q;
  assign stat_len_o = stat_len;

  // Capacity register and message state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      accum_q   <= '0;
      cnt_q     <= 2'd0;
      budget_q  <= 2'd3;
      bw_q      <= '0;
      discard_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        accum_q   <= accum_d;
        cnt_q     <= cnt_d;
        budget_q  <= budget_d;
        bw_q      <= bw_d;
        discard_q <= discard_d;
      end
    end
  end

endmodule

// ===== design/b64d_queue.sv =====
// Small register queue that holds jobs between front and back.
module b64d_queue #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth     = b64d_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DataWidth-1:0] data_i,
  input  logic                 pop_i,
  output logic [DataWidth-1:0] data_o,
  output logic                 empty_o,
  output logic                 full_o
);
  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [PtrWidth-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]  count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CntWidth'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntWidth'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntWidth'(1);
      end
    end
  end

endmodule

// ===== design/b64d_back.sv =====
// Back end: expands each job into result beats through an output register.
module b64d_back #(
  parameter int unsigned CountWidth = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  b64d_pkg::job_t        job_i,
  input  logic [CountWidth-1:0] base_i,
  input  logic [CountWidth-1:0] stat_len_i,
  output logic                  pop_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output b64d_pkg::out_beat_t   out_data_o
);
  import b64d_pkg::*;

  logic                  out_valid_q, out_valid_d;
  out_beat_t             out_data_q, out_data_d;
  logic [1:0]            idx_q, idx_d;
  logic                  load;
  logic [2:0]            total;
  logic                  last;
  logic [CountWidth-1:0] len;
  logic                  pop;

  assign load  = !out_valid_q || !out_stall_i;
  assign total = {1'b0, job_i.nbytes} + {2'b00, job_i.has_stat};
  assign last  = ({1'b0, idx_q} + 3'd1) == total;

  // Form the next beat of the job at the queue head.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    idx_d       = idx_q;
    pop         = 1'b0;
    len         = base_i + CountWidth'(idx_q) + CountWidth'(1);
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        out_data_d.run_end = last;
        if (idx_q < job_i.nbytes) begin
          out_data_d.status    = ST_DATA;
          out_data_d.total_len = LEN_WIDTH'(len);
          case (idx_q)
            2'd0:    out_data_d.out_byte = job_i.group[23:16];
            2'd1:    out_data_d.out_byte = job_i.group[15:8];
            default: out_data_d.out_byte = job_i.group[7:0];
          endcase
        end else begin
          out_data_d.status    = job_i.stat;
          out_data_d.total_len = LEN_WIDTH'(stat_len_i);
          out_data_d.out_byte  = 8'd0;
        end
        pop   = last;
        idx_d = last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Output register and beat index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

// ===== tb/base64_decoder_core_test.sv =====
// Self-checking testbench of the Base64 stream decoder core.
`timescale 1ns / 100ps

module base64_decoder_core_test;
  import b64d_pkg::*;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    ROW_BEAT,
    ROW_TYPED,
    ROW_CAP
  } row_kind_e;

  // One row of the directed table: a beat, a beat with a typed result, or a capacity write.
  typedef struct packed {
    row_kind_e            kind;
    logic [CAP_WIDTH-1:0] cap;
    in_beat_t             beat;
    status_e              want;
  } dir_row_t;

  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED = 40;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CAP_WIDTH-1:0] cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_beat_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_beat_t            out_data_o;

  // Decoder state as the testbench sees it.
  logic [CAP_WIDTH-1:0] cap_q = CAP_RESET;
  logic [23:0]          dec_acc;
  int unsigned          dec_nsym;
  int unsigned          dec_pads;
  logic [15:0]          dec_count;
  bit                   dec_drop;

  out_beat_t new_results[$];
  out_beat_t awaited_results[$];
  dir_row_t  dir_rows[$];

  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int messages_sent = 0;
  int in_idle_pct = 0;
  int stall_pct = 0;

  base64_decoder_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock with a 4 ns period.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("FAIL base64_decoder_core");
    $finish;
  end

  // Maps a character to its 6-bit value, the pad code or the skip code.
  function automatic logic [7:0] char_symbol(logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return ch - "A";
    if (ch >= "a" && ch <= "z") return ch - "a" + 8'd26;
    if (ch >= "0" && ch <= "9") return ch - "0" + 8'd52;
    if (ch == "+") return 8'd62;
    if (ch == "/") return 8'd63;
    if (ch == "=") return SYM_PAD;
    return SYM_SKIP;
  endfunction

  // Maps a 6-bit value back to its character.
  function automatic logic [7:0] b64_char(int unsigned v);
    if (v < 26) return 8'(v) + "A";
    if (v < 52) return 8'(v - 26) + "a";
    if (v < 62) return 8'(v - 52) + "0";
    if (v == 62) return "+";
    return "/";
  endfunction

  function automatic void restart_message();
    dec_acc = '0;
    dec_nsym = 0;
    dec_pads = 3;
    dec_count = '0;
    dec_drop = 1'b0;
  endfunction

  function automatic void add_result(logic [7:0] b, status_e st, logic [15:0] len);
    out_beat_t r;
    r.out_byte = b;
    r.status = st;
    r.total_len = len;
    r.run_end = 1'b0;
    new_results.push_back(r);
  endfunction

  // Works out the result beats that one character causes and updates the decoder state.
  function automatic void decode_char(in_beat_t b);
    logic [7:0]  sym;
    int unsigned n;
    new_results.delete();
    // A message past overflow is dropped silently up to its last character.
    if (dec_drop) begin
      if (b.end_of_message) restart_message();
      return;
    end
    sym = char_symbol(b.in_char);
    if (sym != SYM_SKIP) begin
      if (sym == SYM_PAD) begin
        sym = 8'd0;
        if (dec_pads > 0) dec_pads--;
      end
      dec_acc = {dec_acc[17:0], sym[5:0]};
      dec_nsym++;
      // A full group gives its bytes, or an overflow if they do not fit.
      if (dec_nsym == 4) begin
        n = (dec_pads == 0) ? 1 : dec_pads;
        if ({16'd0, dec_count} + n > {16'd0, cap_q}) begin
          add_result(8'd0, ST_OVERFLOW, dec_count);
          dec_drop = 1'b1;
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            dec_count = dec_count + 16'd1;
            add_result(dec_acc[23 - 8 * i -: 8], ST_DATA, dec_count);
          end
        end
        dec_acc = '0;
        dec_nsym = 0;
      end
    end
    // The last character closes the message with a status unless it overflowed.
    if (b.end_of_message) begin
      if (!dec_drop) add_result(8'd0, (dec_nsym != 0) ? ST_INCOMPLETE : ST_DONE, dec_count);
      restart_message();
    end
    if (new_results.size() > 0) new_results[new_results.size() - 1].run_end = 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (errors < MAX_PRINTED) begin
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // Random receiver stalls.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each accepted result beat with the oldest awaited one.
  always @(posedge clk_i) begin : check_results
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_data_o, 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_data_o.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_data_o.out_byte, want.out_byte);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.total_len !== want.total_len)
          report_mismatch("total_len", out_data_o.total_len, want.total_len);
        if (out_data_o.run_end !== want.run_end)
          report_mismatch("run_end", out_data_o.run_end, want.run_end);
      end
    end
  end

  // Sends one character beat; on acceptance queues either its typed or its predicted results.
  task automatic send_beat(in_beat_t b, bit use_typed, out_beat_t typed_res);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    decode_char(b);
    if (use_typed) awaited_results.push_back(typed_res);
    else foreach (new_results[i]) awaited_results.push_back(new_results[i]);
  endtask

  // Holds the sender off until every awaited result has arrived, optionally settling after.
  task automatic quiesce(bit settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_WIDTH-1:0] value);
    quiesce(1'b1);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_q = value;
  endtask

  // Builds and sends one message: mostly well-formed groups, sometimes random text.
  task automatic send_random_message();
    logic [7:0]  text[$];
    logic [7:0]  c;
    int          groups;
    int          pads;
    int          len;
    in_beat_t    b;
    if ($urandom_range(0, 9) < 7) begin
      groups = $urandom_range(0, 3);
      for (int g = 0; g < groups; g++) begin
        pads = (g == groups - 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            do c = 8'($urandom_range(0, 255)); while (char_symbol(c) != SYM_SKIP);
            text.push_back(c);
          end
          text.push_back((k >= 4 - pads) ? "=" : b64_char($urandom_range(0, 63)));
        end
      end
    end else begin
      len = $urandom_range(1, 7);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: text.push_back(8'($urandom_range(0, 255)));
          5, 6, 7: text.push_back(b64_char($urandom_range(0, 63)));
          default: text.push_back("=");
        endcase
      end
    end
    // An empty message still needs a last character.
    if (text.size() == 0) begin
      do c = 8'($urandom_range(0, 255)); while (char_symbol(c) != SYM_SKIP);
      text.push_back(c);
    end
    foreach (text[i]) begin
      b.in_char = text[i];
      b.end_of_message = (i == text.size() - 1);
      send_beat(b, 1'b0, '0);
    end
    messages_sent++;
  endtask

  // One random phase at a given capacity and idling mix.
  task automatic run_phase(logic [CAP_WIDTH-1:0] cap, int idle, int stall, int n_beats);
    int start;
    int msg;
    write_capacity(cap);
    in_idle_pct = idle;
    stall_pct = stall;
    start = beats_sent;
    msg = 0;
    while (beats_sent - start < n_beats) begin
      send_random_message();
      msg++;
      // Let the output side run dry at most once per phase, after the third message.
      if (msg == 3) quiesce(1'b0);
    end
  endtask

  function automatic dir_row_t beat_row(logic [7:0] ch, logic eom);
    dir_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.beat.in_char = ch;
    r.beat.end_of_message = eom;
    return r;
  endfunction

  function automatic dir_row_t typed_row(logic [7:0] ch, logic eom, status_e st);
    dir_row_t r;
    r = beat_row(ch, eom);
    r.kind = ROW_TYPED;
    r.want = st;
    return r;
  endfunction

  function automatic dir_row_t cap_row(logic [CAP_WIDTH-1:0] value);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CAP;
    r.cap = value;
    return r;
  endfunction

  // Main stimulus: reset, directed table, random phases, drain and verdict.
  initial begin : stimulus
    out_beat_t typed_res;
    restart_message();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      // A lone skipped character closes an empty message.
      typed_row("!", 1'b1, ST_DONE),
      // One symbol and the end leaves a partial group.
      typed_row("A", 1'b1, ST_INCOMPLETE),
      // Plain group, then the top character code closes the message.
      beat_row("T", 1'b0), beat_row("W", 1'b0), beat_row("F", 1'b0), beat_row("u", 1'b0),
      beat_row(8'hFF, 1'b1),
      // Zero character skipped, highest symbols, one pad on the last character.
      beat_row(8'h00, 1'b0), beat_row("+", 1'b0), beat_row("/", 1'b0), beat_row("9", 1'b0),
      beat_row("=", 1'b1),
      // Four pads: the budget saturates at zero and still gives one byte.
      beat_row("=", 1'b0), beat_row("=", 1'b0), beat_row("=", 1'b0), beat_row("=", 1'b1),
      // Zero capacity: overflow on the last character carries the run end.
      cap_row(16'd0),
      beat_row("A", 1'b0), beat_row("A", 1'b0), beat_row("A", 1'b0),
      typed_row("A", 1'b1, ST_OVERFLOW),
      // Overflow mid-message, then the rest of the message is dropped silently.
      cap_row(16'd1),
      beat_row("z", 1'b0), beat_row("z", 1'b0), beat_row("z", 1'b0),
      typed_row("z", 1'b0, ST_OVERFLOW),
      beat_row("a", 1'b0), beat_row("b", 1'b1)
    };

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CAP: write_capacity(dir_rows[i].cap);
        ROW_TYPED: begin
          typed_res.out_byte = 8'd0;
          typed_res.status = dir_rows[i].want;
          typed_res.total_len = '0;
          typed_res.run_end = 1'b1;
          send_beat(dir_rows[i].beat, 1'b1, typed_res);
        end
        default: send_beat(dir_rows[i].beat, 1'b0, '0);
      endcase
    end

    run_phase(16'hFFFF, 0, 0, 50);
    run_phase(16'd0, 84, 0, 50);
    run_phase(16'($urandom_range(1, 12)), 0, 84, 50);
    run_phase(16'($urandom_range(13, 40)), 19, 19, 50);

    quiesce(1'b1);
    $display("Sent %0d character beats in %0d random messages plus the directed table,",
             beats_sent, messages_sent);
    $display("checked %0d result beats over capacities from 0 to 65535.", results_seen);
    if (errors == 0) begin
      $display("PASS base64_decoder_core");
    end else begin
      $display("FAIL base64_decoder_core");
    end
    $finish;
  end

endmodule
